[rtl/core/rpvg_pkg.sv]
package rpvg_pkg;

    localparam int MAX_SIDES_DFLT = 63;

    localparam int SIDES_W = 6;
    localparam int COORD_W = 16;

    // Q2.30 constants
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] RND_HALF    = 31'd32768;

    // shared divider geometry
    localparam int DIV_N_W = 36;
    localparam int DIV_D_W = 7;

    // Taylor sequencer: cos and sin terms interleaved, cos on even steps
    localparam int          TERM_CNT  = 9;
    localparam logic [3:0]  TERM_LAST = 4'(TERM_CNT - 1);

    typedef struct packed {
        logic       load;
        logic       emit_centre;
        logic       div_angle;
        logic       take_angle;
        logic       square;
        logic       div_term;
        logic       acc_term;
        logic       emit_vertex;
        logic       advance;
        logic       reduce;
        logic [3:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic sides_zero;
        logic div_done;
        logic rem_ge_sides;
        logic last_vertex;
    } t_dp_stat;

    // k*(k+1) divisor of each term
    function automatic logic [DIV_D_W-1:0] term_div(input logic [3:0] step);
        logic [DIV_D_W-1:0] d;
        case (step)
            4'd0:    d = 7'd2;
            4'd1:    d = 7'd6;
            4'd2:    d = 7'd12;
            4'd3:    d = 7'd20;
            4'd4:    d = 7'd30;
            4'd5:    d = 7'd42;
            4'd6:    d = 7'd56;
            4'd7:    d = 7'd72;
            4'd8:    d = 7'd90;
            default: d = 7'd90;
        endcase
        return d;
    endfunction

    // alternating signs: first term of each series subtracts
    function automatic logic term_sub(input logic [3:0] step);
        logic s;
        case (step)
            4'd0, 4'd1, 4'd4, 4'd5, 4'd8: s = 1'b1;
            default:                      s = 1'b0;
        endcase
        return s;
    endfunction

endpackage

[rtl/core/rpvg_div.sv]
module rpvg_div #(
    parameter int N_W = rpvg_pkg::DIV_N_W,
    parameter int D_W = rpvg_pkg::DIV_D_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic [N_W-1:0] o_quotient,
    output logic           o_done
);
    // radix-4 restoring divider, two quotient bits per cycle
    localparam int STEPS = (N_W + 1) / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic [N_W-1:0]   r_num;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D_W+1:0] t_part;
    logic [D_W+1:0] d1, d2, d3;
    logic [D_W+1:0] n_part;
    logic [1:0]     n_digit;

    always_comb begin
        t_part = {r_rem, r_num[N_W-1:N_W-2]};
        d1     = {2'b00, r_den};
        d2     = {1'b0, r_den, 1'b0};
        d3     = d1 + d2;
        if (t_part >= d3) begin
            n_digit = 2'd3;
            n_part  = t_part - d3;
        end else if (t_part >= d2) begin
            n_digit = 2'd2;
            n_part  = t_part - d2;
        end else if (t_part >= d1) begin
            n_digit = 2'd1;
            n_part  = t_part - d1;
        end else begin
            n_digit = 2'd0;
            n_part  = t_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[N_W-3:0], n_digit};
            r_rem <= n_part[D_W-1:0];
        end
    end

    assign o_quotient = r_num;
    assign o_done     = r_done;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");

endmodule

[rtl/core/rpvg_ctrl.sv]
module rpvg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  rpvg_pkg::t_dp_stat i_stat,
    output rpvg_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import rpvg_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CENTRE    = 4'd1;
    localparam logic [3:0] S_ANGLE     = 4'd2;
    localparam logic [3:0] S_WAIT_ANG  = 4'd3;
    localparam logic [3:0] S_SQUARE    = 4'd4;
    localparam logic [3:0] S_TERM      = 4'd5;
    localparam logic [3:0] S_WAIT_TERM = 4'd6;
    localparam logic [3:0] S_EMIT      = 4'd7;
    localparam logic [3:0] S_REDUCE    = 4'd8;

    logic [3:0] r_state, n_state;
    logic [3:0] r_step,  n_step;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CENTRE;
                end
            end
            S_CENTRE: begin
                o_cmd.emit_centre = 1'b1;
                n_state = i_stat.sides_zero ? S_IDLE : S_ANGLE;
            end
            S_ANGLE: begin
                o_cmd.div_angle = 1'b1;
                n_state = S_WAIT_ANG;
            end
            S_WAIT_ANG: begin
                if (i_stat.div_done) begin
                    o_cmd.take_angle = 1'b1;
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_step  = '0;
                n_state = S_TERM;
            end
            S_TERM: begin
                o_cmd.div_term = 1'b1;
                n_state = S_WAIT_TERM;
            end
            S_WAIT_TERM: begin
                if (i_stat.div_done) begin
                    o_cmd.acc_term = 1'b1;
                    if (r_step == TERM_LAST) begin
                        n_state = S_EMIT;
                    end else begin
                        n_step  = r_step + 1'b1;
                        n_state = S_TERM;
                    end
                end
            end
            S_EMIT: begin
                o_cmd.emit_vertex = 1'b1;
                if (i_stat.last_vertex) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_stat.rem_ge_sides) begin
                    o_cmd.reduce = 1'b1;
                end else begin
                    n_state = S_ANGLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= TERM_LAST)
        else $error("term step out of range");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && i_stat.last_vertex |=> (r_state == S_IDLE))
        else $error("final vertex did not end the item");

endmodule

[rtl/core/rpvg_datapath.sv]
module rpvg_datapath #(
    parameter int MAX_SIDES = rpvg_pkg::MAX_SIDES_DFLT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rpvg_pkg::t_dp_cmd                 i_cmd,
    input  logic [rpvg_pkg::SIDES_W-1:0]      i_sides,
    output rpvg_pkg::t_dp_stat                o_stat,
    output logic                              o_valid,
    output logic [rpvg_pkg::SIDES_W-1:0]      o_vertex_index,
    output logic signed [rpvg_pkg::COORD_W-1:0] o_x_coord,
    output logic signed [rpvg_pkg::COORD_W-1:0] o_y_coord,
    output logic                              o_last_vertex
);
    import rpvg_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam logic [SIDES_W-1:0] SIDES_CAP = SIDES_W'(MAX_SIDES);

    logic [SIDES_W-1:0] r_sides;
    logic [SIDES_W-1:0] r_vi;     // vertex number i, output index is i+1
    logic [1:0]         r_quad;
    logic [SIDES_W:0]   r_rem;    // 4i - quad*s, may exceed s until reduced
    logic [29:0]        r_a;
    logic [29:0]        r_a2;
    logic [30:0]        r_ts, r_tc, r_sn, r_cs;

    logic                     r_valid;
    logic [SIDES_W-1:0]       r_vertex_index;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic                     r_last;

    logic                 swap;
    logic [SIDES_W-1:0]   rem_red;
    logic [36:0]          ang_prod;
    logic [59:0]          sq_prod;
    logic [30:0]          prev;
    logic [60:0]          term_prod;
    logic [DIV_N_W-1:0]   div_num;
    logic [DIV_D_W-1:0]   div_den;
    logic [DIV_N_W-1:0]   div_quo;
    logic                 div_done;
    logic                 is_cos;
    logic [30:0]          cs_rnd, sn_rnd;
    logic signed [COORD_W-1:0] c_val, s_val, c_sw, s_sw;
    logic [SIDES_W-1:0]   vi_next;

    assign vi_next = r_vi + 1'b1;
    assign swap    = {r_rem, 1'b0} > {2'b00, r_sides};
    assign rem_red = swap ? (r_sides - r_rem[SIDES_W-1:0]) : r_rem[SIDES_W-1:0];
    assign is_cos  = ~i_cmd.step[0];

    always_comb begin
        ang_prod  = HALF_PI_Q30 * rem_red;
        sq_prod   = r_a * r_a;
        prev      = is_cos ? r_tc : r_ts;
        term_prod = prev * r_a2;
        if (i_cmd.div_angle) begin
            div_num = ang_prod[DIV_N_W-1:0];
            div_den = {1'b0, r_sides};
        end else begin
            div_num = {{(DIV_N_W-31){1'b0}}, term_prod[60:30]};
            div_den = term_div(i_cmd.step);
        end
    end

    rpvg_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_angle | i_cmd.div_term),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sides <= (i_sides > SIDES_CAP) ? SIDES_CAP : i_sides;
            r_vi    <= '0;
            r_quad  <= QUAD_0;
            r_rem   <= '0;
        end
        if (i_cmd.advance) begin
            r_vi  <= vi_next;
            r_rem <= r_rem + (SIDES_W+1)'(4);
        end
        if (i_cmd.reduce) begin
            r_rem  <= r_rem - {1'b0, r_sides};
            r_quad <= r_quad + 1'b1;
        end
        if (i_cmd.take_angle) begin
            r_a  <= div_quo[29:0];
            r_ts <= {1'b0, div_quo[29:0]};
            r_sn <= {1'b0, div_quo[29:0]};
            r_tc <= Q30_ONE;
            r_cs <= Q30_ONE;
        end
        if (i_cmd.square) begin
            r_a2 <= sq_prod[59:30];
        end
        if (i_cmd.acc_term) begin
            if (is_cos) begin
                r_tc <= div_quo[30:0];
                r_cs <= term_sub(i_cmd.step) ? r_cs - div_quo[30:0]
                                             : r_cs + div_quo[30:0];
            end else begin
                r_ts <= div_quo[30:0];
                r_sn <= term_sub(i_cmd.step) ? r_sn - div_quo[30:0]
                                             : r_sn + div_quo[30:0];
            end
        end
    end

    // round Q2.30 to Q2.14, then fold the octant and quadrant back in
    always_comb begin
        cs_rnd = r_cs + RND_HALF;
        sn_rnd = r_sn + RND_HALF;
        c_val  = {1'b0, cs_rnd[30:16]};
        s_val  = {1'b0, sn_rnd[30:16]};
        c_sw   = swap ? s_val : c_val;
        s_sw   = swap ? c_val : s_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_centre | i_cmd.emit_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_centre) begin
            r_vertex_index <= '0;
            r_x            <= '0;
            r_y            <= '0;
            r_last         <= (r_sides == '0);
        end else if (i_cmd.emit_vertex) begin
            r_vertex_index <= vi_next;
            r_last         <= (vi_next == r_sides);
            case (r_quad)
                QUAD_0: begin
                    r_x <= c_sw;
                    r_y <= s_sw;
                end
                QUAD_1: begin
                    r_x <= -s_sw;
                    r_y <= c_sw;
                end
                QUAD_2: begin
                    r_x <= -c_sw;
                    r_y <= -s_sw;
                end
                default: begin
                    r_x <= s_sw;
                    r_y <= -c_sw;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.sides_zero   = (r_sides == '0);
        o_stat.div_done     = div_done;
        o_stat.rem_ge_sides = (r_rem >= {1'b0, r_sides});
        o_stat.last_vertex  = (vi_next == r_sides);
    end

    assign o_valid        = r_valid;
    assign o_vertex_index = r_vertex_index;
    assign o_x_coord      = r_x;
    assign o_y_coord      = r_y;
    assign o_last_vertex  = r_last;

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_angle |-> (r_rem < {1'b0, r_sides}))
        else $error("angle started before remainder was reduced");

endmodule

[rtl/core/regular_polygon_vertex_generator_top.sv]
// Channel    Handshake            Payload
// ---------  -------------------  -------------------------------------------------
// command    start / busy         i_sides
// result     o_valid (strobe)     o_vertex_index, o_x_coord, o_y_coord, o_last_vertex
//
// A command beat is taken when start is high and busy is low; s+1 result beats follow.
// The centre beat follows the command via the CENTRE state and the strobe register; each vertex
// then needs the angle division and 9 Taylor terms, all on the one shared radix-4 divider,
// plus quadrant bookkeeping.
// Synchronous active-low reset returns the sequencer to idle and drops the strobe.
// Results cannot be stalled; each strobe lasts one cycle.
module regular_polygon_vertex_generator_top #(
    parameter int MAX_SIDES = rpvg_pkg::MAX_SIDES_DFLT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rpvg_pkg::SIDES_W-1:0]        i_sides,
    output logic                                o_valid,
    output logic [rpvg_pkg::SIDES_W-1:0]        o_vertex_index,
    output logic signed [rpvg_pkg::COORD_W-1:0] o_x_coord,
    output logic signed [rpvg_pkg::COORD_W-1:0] o_y_coord,
    output logic                                o_last_vertex
);
    import rpvg_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rpvg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rpvg_datapath #(
        .MAX_SIDES (MAX_SIDES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sides        (i_sides),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_vertex_index (o_vertex_index),
        .o_x_coord      (o_x_coord),
        .o_y_coord      (o_y_coord),
        .o_last_vertex  (o_last_vertex)
    );

endmodule

[dv/regular_polygon_vertex_generator_top_tb.sv]
`timescale 1ns / 1ps

module regular_polygon_vertex_generator_top_tb;

    import rpvg_pkg::*;

    localparam int          SIDE_CAP    = MAX_SIDES_DFLT;
    localparam int          N_RANDOM    = 280;
    localparam int          STALL_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 300;
    // Q2.30 angle and unit constants
    localparam longint unsigned QUARTER_TURN_FX = 64'd1686629713;
    localparam longint unsigned UNIT_FX         = 64'd1073741824;

    typedef struct {
        logic [SIDES_W-1:0]        index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } vertex_t;

    typedef struct {
        logic [SIDES_W-1:0] sides;
        bit                 hold_for_drain;
    } polygon_cmd_t;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start   = 1'b0;
    logic [SIDES_W-1:0]        i_sides = '0;
    logic                      busy;
    logic                      o_valid;
    logic [SIDES_W-1:0]        o_vertex_index;
    logic signed [COORD_W-1:0] o_x_coord;
    logic signed [COORD_W-1:0] o_y_coord;
    logic                      o_last_vertex;

    polygon_cmd_t polygon_q[$];
    vertex_t      vertex_q[$];
    int unsigned  polygons_total    = 0;
    int unsigned  polygons_accepted = 0;
    int unsigned  vertices_checked  = 0;
    int unsigned  mismatches        = 0;
    int unsigned  gap_left          = 0;
    int unsigned  idle_cycles       = 0;
    logic         drained           = 1'b1;

    regular_polygon_vertex_generator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sides        (i_sides),
        .o_valid        (o_valid),
        .o_vertex_index (o_vertex_index),
        .o_x_coord      (o_x_coord),
        .o_y_coord      (o_y_coord),
        .o_last_vertex  (o_last_vertex)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint unsigned taylor_next(input longint unsigned prev,
                                                    input longint unsigned a2,
                                                    input longint unsigned div);
        return ((prev * a2) >> 30) / div;
    endfunction

    // point at idx/n of a full turn, Q2.14
    function automatic void circle_point(input int unsigned idx, input int unsigned n,
                                         output logic signed [COORD_W-1:0] px,
                                         output logic signed [COORD_W-1:0] py);
        int unsigned     quad;
        int unsigned     rem;
        bit              swap;
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned t;
        longint unsigned sin_acc;
        longint unsigned cos_acc;
        int              c;
        int              s;
        int              tmp;
        quad = (4 * idx) / n;
        rem  = 4 * idx - quad * n;
        swap = (2 * rem) > n;
        if (swap) begin
            rem = n - rem;
        end
        ang  = (QUARTER_TURN_FX * longint'(rem)) / longint'(n);
        ang2 = (ang * ang) >> 30;

        t = ang; sin_acc = ang;
        t = taylor_next(t, ang2, 6);  sin_acc -= t;
        t = taylor_next(t, ang2, 20); sin_acc += t;
        t = taylor_next(t, ang2, 42); sin_acc -= t;
        t = taylor_next(t, ang2, 72); sin_acc += t;

        t = UNIT_FX; cos_acc = UNIT_FX;
        t = taylor_next(t, ang2, 2);  cos_acc -= t;
        t = taylor_next(t, ang2, 12); cos_acc += t;
        t = taylor_next(t, ang2, 30); cos_acc -= t;
        t = taylor_next(t, ang2, 56); cos_acc += t;
        t = taylor_next(t, ang2, 90); cos_acc -= t;

        c = int'((cos_acc + 64'd32768) >> 16);
        s = int'((sin_acc + 64'd32768) >> 16);
        if (swap) begin
            tmp = c; c = s; s = tmp;
        end
        case (quad & 3)
            0: begin px = COORD_W'(c);  py = COORD_W'(s);  end
            1: begin px = COORD_W'(-s); py = COORD_W'(c);  end
            2: begin px = COORD_W'(-c); py = COORD_W'(-s); end
            default: begin px = COORD_W'(s); py = COORD_W'(-c); end
        endcase
    endfunction

    function automatic void queue_polygon_vertices(input logic [SIDES_W-1:0] sides);
        int unsigned n;
        vertex_t     v;
        n = sides;
        if (n > SIDE_CAP) begin
            n = SIDE_CAP;
        end
        v = '{index: '0, x: '0, y: '0, last: (n == 0)};
        vertex_q.push_back(v);
        for (int unsigned i = 0; i < n; i++) begin
            v.index = SIDES_W'(i + 1);
            circle_point(i, n, v.x, v.y);
            v.last = ((i + 1) == n);
            vertex_q.push_back(v);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 300);
    endfunction

    // mostly small polygons keep the run short; a few reach the top of the range
    function automatic logic [SIDES_W-1:0] pick_sides();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return SIDES_W'($urandom_range(0, 8));
        end else if (r < 95) begin
            return SIDES_W'($urandom_range(9, 24));
        end
        return SIDES_W'($urandom_range(25, 63));
    endfunction

    task automatic check_field(input string fname, input logic [SIDES_W-1:0] vidx,
                               input logic signed [COORD_W:0] want,
                               input logic signed [COORD_W:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: vertex %0d %s mismatch: expected %0d, actual %0d",
                     $time, vidx, fname, want, got);
        end
    endtask

    // command driver
    always @(posedge i_clk) begin : drv_proc
        polygon_cmd_t nxt;
        logic         next_start;
        logic         taken;
        if (!i_rst_n) begin
            start   <= 1'b0;
            i_sides <= '0;
        end else begin
            taken      = start && !busy;
            next_start = start;
            if (taken) begin
                next_start = 1'b0;
                gap_left   = pick_gap();
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (polygon_q.size() > 0 &&
                             (!polygon_q[0].hold_for_drain || (drained && !taken))) begin
                    nxt        = polygon_q.pop_front();
                    next_start = 1'b1;
                    i_sides   <= nxt.sides;
                end
            end
            start <= next_start;
        end
    end

    // result monitor; also predicts on each accepted command beat
    always @(posedge i_clk) begin : mon_proc
        vertex_t want;
        if (!i_rst_n) begin
            drained <= 1'b1;
        end else begin
            if (o_valid) begin
                vertices_checked++;
                if (vertex_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected vertex beat: expected none, actual idx %0d x %0d y %0d last %0b",
                             $time, o_vertex_index, o_x_coord, o_y_coord, o_last_vertex);
                end else begin
                    want = vertex_q.pop_front();
                    check_field("index", want.index, want.index, o_vertex_index);
                    check_field("x", want.index, want.x, o_x_coord);
                    check_field("y", want.index, want.y, o_y_coord);
                    check_field("last", want.index, want.last, o_last_vertex);
                end
            end
            if (start && !busy) begin
                polygons_accepted++;
                queue_polygon_vertices(i_sides);
            end
            drained <= (vertex_q.size() == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d vertices outstanding",
                         $time, idle_cycles, vertex_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [SIDES_W-1:0] directed[] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
                                          6'd8, 6'd12, 6'd16, 6'd32, 6'd63, 6'd62, 6'd31,
                                          6'd0, 6'd2, 6'd1, 6'd3, 6'd0, 6'd5};
        polygon_cmd_t       c;
        foreach (directed[k]) begin
            c.sides          = directed[k];
            c.hold_for_drain = (k == 12);  // wait out the 63-gon alone
            polygon_q.push_back(c);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            c.sides          = pick_sides();
            c.hold_for_drain = ($urandom_range(0, 99) < 3);
            polygon_q.push_back(c);
        end
        polygons_total = polygon_q.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample on the falling edge so posedge updates have settled
        do begin
            @(negedge i_clk);
        end while (polygons_accepted != polygons_total || !drained);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Generated %0d polygons (%0d directed, side counts 0 to 63)",
                 polygons_accepted, directed.size());
        $display("Checked %0d vertex beats, %0d field mismatches", vertices_checked, mismatches);
        if (mismatches == 0 && vertex_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
